>>> rtl/bdeq_pkg.sv
// package for the button debounce event queue
// shared types, register indexes, event codes and reset values; no dependencies
`default_nettype none

package bdeq_pkg;

   localparam int TIME_W      = 32;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int LEVELS_W    = 4;

   // register indexes
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type REG_DEBOUNCE_TIME     = 2'd0;
   localparam csr_index_type REG_LONG_PRESS_TIME   = 2'd1;
   localparam csr_index_type REG_REPEAT_START_TIME = 2'd2;
   localparam csr_index_type REG_REPEAT_PERIOD     = 2'd3;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] DEBOUNCE_TIME_RESET     = 16'd30;
   localparam logic [CSR_DATA_W-1:0] LONG_PRESS_TIME_RESET   = 16'd800;
   localparam logic [CSR_DATA_W-1:0] REPEAT_START_TIME_RESET = 16'd400;
   localparam logic [CSR_DATA_W-1:0] REPEAT_PERIOD_RESET     = 16'd120;

   // command codes
   typedef logic cmd_type;
   localparam cmd_type CMD_SAMPLE = 1'b0;
   localparam cmd_type CMD_POP    = 1'b1;

   // button codes
   typedef logic [1:0] btn_type;
   localparam btn_type BTN_UP     = 2'd0;
   localparam btn_type BTN_DOWN   = 2'd1;
   localparam btn_type BTN_SELECT = 2'd2;
   localparam btn_type BTN_BACK   = 2'd3;

   // action codes
   typedef logic [1:0] action_type;
   localparam action_type ACT_PRESS  = 2'd0;
   localparam action_type ACT_LONG   = 2'd1;
   localparam action_type ACT_REPEAT = 2'd2;

   // one queued event
   typedef struct packed {
      btn_type    button;
      action_type action;
   } event_type;

   // sequencer to queue
   typedef struct packed {
      logic      push;
      event_type push_event;
      logic      pop;
   } queue_ctl_type;

   // queue to sequencer
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

>>> rtl/bdeq_req_if.sv
// request channel interface: sample or pop command with timestamp and levels
// depends on bdeq_pkg
`default_nettype none

interface bdeq_req_if
   import bdeq_pkg::*;
   ;
   logic                valid;
   logic                ready;
   cmd_type             cmd;
   logic [TIME_W-1:0]   now_ms;
   logic [LEVELS_W-1:0] pressed_levels;

   modport source (output valid, output cmd, output now_ms, output pressed_levels,
                   input ready);
   modport sink   (input valid, input cmd, input now_ms, input pressed_levels,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/bdeq_rsp_if.sv
// response channel interface: popped event and queue fill level
// depends on bdeq_pkg
`default_nettype none

interface bdeq_rsp_if
   import bdeq_pkg::*;
   ;
   logic       valid;
   logic       ready;
   logic       event_valid;
   btn_type    event_button;
   action_type event_action;
   logic [3:0] queued_count;

   modport source (output valid, output event_valid, output event_button,
                   output event_action, output queued_count, input ready);
   modport sink   (input valid, input event_valid, input event_button,
                   input event_action, input queued_count, output ready);
endinterface

`default_nettype wire

>>> rtl/bdeq_elapsed_unit.sv
// shared elapsed-time unit: wrapping 32-bit subtract and compare to a threshold
// depends on bdeq_pkg
`default_nettype none

module bdeq_elapsed_unit
   import bdeq_pkg::*;
   (
   input  logic [TIME_W-1:0]     now_ms,
   input  logic [TIME_W-1:0]     stamp,
   input  logic [CSR_DATA_W-1:0] threshold,
   output logic                  reached
   );

   logic [TIME_W-1:0] elapsed;

   // time differences wrap modulo 2^32
   assign elapsed = now_ms - stamp;
   assign reached = elapsed >= TIME_W'(threshold);

endmodule

`default_nettype wire

>>> rtl/bdeq_event_queue.sv
// ring queue of events with registered read port; holds up to QUEUE_SLOTS-1 events
// depends on bdeq_pkg
`default_nettype none

module bdeq_event_queue
   import bdeq_pkg::*;
   #(
   parameter int QUEUE_SLOTS = 16,
   localparam int PTR_W = $clog2(QUEUE_SLOTS)
   )
   (
   input  logic             clock,
   input  logic             reset,
   input  queue_ctl_type    ctl,
   output queue_status_type status,
   output logic [PTR_W-1:0] count,
   output event_type        rd_event
   );

   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);

   event_type        store [QUEUE_SLOTS];
   event_type        rd_event_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic [PTR_W-1:0] rd_ptr_next;
   logic [PTR_W:0]   wrapped_count;
   logic             do_push;
   logic             do_pop;

   // pointer wrap
   assign wr_ptr_next = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_next = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;

   assign status.empty = wr_ptr_ff == rd_ptr_ff;
   assign status.full  = wr_ptr_next == rd_ptr_ff;

   // new events are dropped when full
   assign do_push = ctl.push && !status.full;
   assign do_pop  = ctl.pop && !status.empty;

   // fill level modulo the slot count
   assign wrapped_count = {1'b0, wr_ptr_ff} + (PTR_W+1)'(QUEUE_SLOTS) - {1'b0, rd_ptr_ff};
   assign count = (wr_ptr_ff >= rd_ptr_ff) ? wr_ptr_ff - rd_ptr_ff
                                           : wrapped_count[PTR_W-1:0];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_next : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_next : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // event memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ptr_ff] <= ctl.push_event;
      end
      if (do_pop) begin
         rd_event_ff <= store[rd_ptr_ff];
      end
   end

   assign rd_event = rd_event_ff;

   // fill level never reaches the slot count
   assert property (@(posedge clock) disable iff (reset) count <= LAST_SLOT)
      else $error("queue fill level exceeds capacity");

   // a push into a full queue leaves the write pointer alone
   assert property (@(posedge clock) disable iff (reset)
      (ctl.push && status.full) |=> $stable(wr_ptr_ff))
      else $error("push into full queue moved write pointer");

   // a pop of an empty queue leaves the read pointer alone
   assert property (@(posedge clock) disable iff (reset)
      (ctl.pop && status.empty) |=> $stable(rd_ptr_ff))
      else $error("pop of empty queue moved read pointer");

endmodule

`default_nettype wire

>>> rtl/button_debounce_event_queue.sv
// top level: sequencer, per-button state and response register
// depends on bdeq_pkg, bdeq_req_if, bdeq_rsp_if, bdeq_elapsed_unit, bdeq_event_queue
`default_nettype none

// Four buttons (up, down, select, back) are debounced by time from millisecond
// samples and turned into press, long-press and auto-repeat events kept in a
// ring queue of QUEUE_SLOTS slots (QUEUE_SLOTS-1 usable; new events are dropped
// when full). A sample transaction (cmd 0) runs from acceptance to the
// response in sequencer steps: up and down take four steps each (debounce, long
// press, repeat start, repeat period) and select and back take two, all on one
// shared 32-bit elapsed-time subtract and compare unit, then a done step loads
// the response. A pop transaction (cmd 1) has a pop step, with the registered
// read of the event memory, and the done step. The request side is ready only while
// the sequencer is idle; a finished response waits in its output register, so
// a new request is taken while the previous response is still pending.
module button_debounce_event_queue
   import bdeq_pkg::*;
   #(
   parameter int QUEUE_SLOTS = 16
   )
   (
   input  logic                  clock,
   input  logic                  reset,
   bdeq_req_if.sink              req_chan,
   bdeq_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
   );

   localparam int PTR_W   = $clog2(QUEUE_SLOTS);
   localparam int BTN_NUM = 4;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DEB    = 7'b0000010,
      ST_LONG   = 7'b0000100,
      ST_RSTART = 7'b0001000,
      ST_RPER   = 7'b0010000,
      ST_POP    = 7'b0100000,
      ST_DONE   = 7'b1000000
   } seq_state_type;

   // configuration registers
   logic [CSR_DATA_W-1:0] debounce_time_ff;
   logic [CSR_DATA_W-1:0] long_press_time_ff;
   logic [CSR_DATA_W-1:0] repeat_start_time_ff;
   logic [CSR_DATA_W-1:0] repeat_period_ff;

   // sequencer
   seq_state_type       state_ff, state_in;
   btn_type             btn_ff, btn_in;
   logic                start_ok_ff, start_ok_in;
   logic                pop_hit_ff, pop_hit_in;
   logic [TIME_W-1:0]   now_ff;
   logic [LEVELS_W-1:0] levels_ff;

   // per-button state
   logic [BTN_NUM-1:0] raw_last_ff, raw_last_in;
   logic [BTN_NUM-1:0] stable_ff, stable_in;
   logic [BTN_NUM-1:0] long_fired_ff, long_fired_in;
   logic [TIME_W-1:0]  deb_stamp_ff [BTN_NUM];
   logic [TIME_W-1:0]  deb_stamp_in [BTN_NUM];
   logic [TIME_W-1:0]  press_start_ff [BTN_NUM];
   logic [TIME_W-1:0]  press_start_in [BTN_NUM];
   logic [TIME_W-1:0]  repeat_stamp_ff [BTN_NUM];
   logic [TIME_W-1:0]  repeat_stamp_in [BTN_NUM];

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_event_valid_ff;
   btn_type    rsp_button_ff;
   action_type rsp_action_ff;
   logic [3:0] rsp_count_ff;
   logic       rsp_load;

   // shared unit and queue
   logic [TIME_W-1:0]     unit_stamp;
   logic [CSR_DATA_W-1:0] unit_threshold;
   logic                  reached;
   queue_ctl_type         queue_ctl;
   queue_status_type      queue_status;
   logic [PTR_W-1:0]      queue_count;
   logic [PTR_W+3:0]      queue_count_wide;
   event_type             rd_event;

   logic accept;
   logic raw;
   logic raw_chg;
   logic repeat_btn;
   logic last_btn;

   assign req_chan.ready = state_ff == ST_IDLE;
   assign accept         = req_chan.valid && req_chan.ready;

   assign raw        = levels_ff[btn_ff];
   assign raw_chg    = raw != raw_last_ff[btn_ff];
   assign repeat_btn = (btn_ff == BTN_UP) || (btn_ff == BTN_DOWN);
   assign last_btn   = btn_ff == BTN_BACK;

   // configuration write port
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff     <= DEBOUNCE_TIME_RESET;
         long_press_time_ff   <= LONG_PRESS_TIME_RESET;
         repeat_start_time_ff <= REPEAT_START_TIME_RESET;
         repeat_period_ff     <= REPEAT_PERIOD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_DEBOUNCE_TIME:     debounce_time_ff     <= csr_wdata;
            REG_LONG_PRESS_TIME:   long_press_time_ff   <= csr_wdata;
            REG_REPEAT_START_TIME: repeat_start_time_ff <= csr_wdata;
            REG_REPEAT_PERIOD:     repeat_period_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // operand select for the shared elapsed-time unit
   always_comb begin
      case (state_ff)
         ST_DEB: begin
            unit_stamp     = raw_chg ? now_ff : deb_stamp_ff[btn_ff];
            unit_threshold = debounce_time_ff;
         end
         ST_LONG: begin
            unit_stamp     = press_start_ff[btn_ff];
            unit_threshold = long_press_time_ff;
         end
         ST_RSTART: begin
            unit_stamp     = press_start_ff[btn_ff];
            unit_threshold = repeat_start_time_ff;
         end
         ST_RPER: begin
            unit_stamp     = repeat_stamp_ff[btn_ff];
            unit_threshold = repeat_period_ff;
         end
         default: begin
            unit_stamp     = press_start_ff[btn_ff];
            unit_threshold = long_press_time_ff;
         end
      endcase
   end

   bdeq_elapsed_unit u_elapsed (
      .now_ms    (now_ff),
      .stamp     (unit_stamp),
      .threshold (unit_threshold),
      .reached   (reached)
   );

   bdeq_event_queue #(
      .QUEUE_SLOTS (QUEUE_SLOTS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctl      (queue_ctl),
      .status   (queue_status),
      .count    (queue_count),
      .rd_event (rd_event)
   );

   // sequencer: one step per cycle while not waiting in idle or done, one button at a time
   always_comb begin
      state_in        = state_ff;
      btn_in          = btn_ff;
      start_ok_in     = start_ok_ff;
      pop_hit_in      = pop_hit_ff;
      raw_last_in     = raw_last_ff;
      stable_in       = stable_ff;
      long_fired_in   = long_fired_ff;
      deb_stamp_in    = deb_stamp_ff;
      press_start_in  = press_start_ff;
      repeat_stamp_in = repeat_stamp_ff;
      queue_ctl                   = '0;
      queue_ctl.push_event.button = btn_ff;
      queue_ctl.push_event.action = ACT_PRESS;
      rsp_load        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pop_hit_in = 1'b0;
               btn_in     = BTN_UP;
               state_in   = (req_chan.cmd == CMD_POP) ? ST_POP : ST_DEB;
            end
         end
         ST_DEB: begin
            raw_last_in[btn_ff] = raw;
            if (raw_chg) begin
               deb_stamp_in[btn_ff] = now_ff;
            end
            // level held long enough and differs from the stable one
            if (reached && (raw != stable_ff[btn_ff])) begin
               stable_in[btn_ff]     = raw;
               long_fired_in[btn_ff] = 1'b0;
               if (raw) begin
                  press_start_in[btn_ff]      = now_ff;
                  repeat_stamp_in[btn_ff]     = now_ff;
                  queue_ctl.push              = 1'b1;
                  queue_ctl.push_event.action = ACT_PRESS;
               end else begin
                  press_start_in[btn_ff]  = '0;
                  repeat_stamp_in[btn_ff] = '0;
               end
            end
            state_in = ST_LONG;
         end
         ST_LONG: begin
            // long press fires once per hold
            if (stable_ff[btn_ff] && !long_fired_ff[btn_ff] && reached) begin
               long_fired_in[btn_ff]       = 1'b1;
               queue_ctl.push              = 1'b1;
               queue_ctl.push_event.action = ACT_LONG;
            end
            if (repeat_btn) begin
               state_in = ST_RSTART;
            end else if (last_btn) begin
               state_in = ST_DONE;
            end else begin
               btn_in   = btn_type'(btn_ff + 2'd1);
               state_in = ST_DEB;
            end
         end
         ST_RSTART: begin
            start_ok_in = reached;
            state_in    = ST_RPER;
         end
         ST_RPER: begin
            // auto-repeat while the raw level is still pressed
            if (stable_ff[btn_ff] && raw && start_ok_ff && reached) begin
               repeat_stamp_in[btn_ff]     = now_ff;
               queue_ctl.push              = 1'b1;
               queue_ctl.push_event.action = ACT_REPEAT;
            end
            if (last_btn) begin
               state_in = ST_DONE;
            end else begin
               btn_in   = btn_type'(btn_ff + 2'd1);
               state_in = ST_DEB;
            end
         end
         ST_POP: begin
            pop_hit_in    = !queue_status.empty;
            queue_ctl.pop = !queue_status.empty;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and button state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         btn_ff          <= BTN_UP;
         start_ok_ff     <= 1'b0;
         pop_hit_ff      <= 1'b0;
         raw_last_ff     <= '0;
         stable_ff       <= '0;
         long_fired_ff   <= '0;
         deb_stamp_ff    <= '{default: '0};
         press_start_ff  <= '{default: '0};
         repeat_stamp_ff <= '{default: '0};
      end else begin
         state_ff        <= state_in;
         btn_ff          <= btn_in;
         start_ok_ff     <= start_ok_in;
         pop_hit_ff      <= pop_hit_in;
         raw_last_ff     <= raw_last_in;
         stable_ff       <= stable_in;
         long_fired_ff   <= long_fired_in;
         deb_stamp_ff    <= deb_stamp_in;
         press_start_ff  <= press_start_in;
         repeat_stamp_ff <= repeat_stamp_in;
      end
   end

   // request payload capture
   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff    <= req_chan.now_ms;
         levels_ff <= req_chan.pressed_levels;
      end
   end

   // response register
   assign queue_count_wide = {4'b0, queue_count};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_event_valid_ff <= pop_hit_ff;
         rsp_button_ff      <= pop_hit_ff ? rd_event.button : BTN_UP;
         rsp_action_ff      <= pop_hit_ff ? rd_event.action : ACT_PRESS;
         rsp_count_ff       <= queue_count_wide[3:0];
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.event_valid  = rsp_event_valid_ff;
   assign rsp_chan.event_button = rsp_button_ff;
   assign rsp_chan.event_action = rsp_action_ff;
   assign rsp_chan.queued_count = rsp_count_ff;

   // events are queued only from the button steps
   assert property (@(posedge clock) disable iff (reset)
      queue_ctl.push |-> (state_ff == ST_DEB || state_ff == ST_LONG || state_ff == ST_RPER))
      else $error("event push outside a button step");

   // the queue is read only by a pop transaction
   assert property (@(posedge clock) disable iff (reset)
      queue_ctl.pop |-> (state_ff == ST_POP && !queue_status.empty))
      else $error("queue pop outside pop step");

   // repeat steps run only for up and down
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RSTART || state_ff == ST_RPER) |-> repeat_btn)
      else $error("repeat step for a button without auto-repeat");

   // a response is loaded only when the output register is free or being taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("response overwritten before it was taken");

endmodule

`default_nettype wire
